[rtl/core/linear_recurrence_nth_term_mod_top_assert.svh]
// Assertion helpers for the RTL of the recurrence block, used by its top module.
// Both forms sample on clk and stand down while rst is high.
`ifndef LINEAR_RECURRENCE_NTH_TERM_MOD_TOP_ASSERT_SVH
`define LINEAR_RECURRENCE_NTH_TERM_MOD_TOP_ASSERT_SVH

// Same-cycle implication.
`define LRN_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LRN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/lrn_pkg.sv]
`default_nettype none

package lrn_pkg;

  localparam int MAX_ORDER = 16;
  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 4;
  localparam int VAL_W     = 30;
  localparam int N_W       = 63;
  localparam int ORDER_W   = 5;

  localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

  // Barrett constant floor(2^60 / PRIME), fits in 31 bits.
  localparam logic [63:0] MU_WIDE = 64'h1000_0000_0000_0000 / 64'(PRIME);
  localparam logic [30:0] MU      = MU_WIDE[30:0];

  localparam logic [CMD_W-1:0] CMD_LOAD_COEF = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_INIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] addend;
  } mul_req_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
  } mul_rsp_t;

endpackage

`default_nettype wire

[rtl/core/lrn_if.sv]
`default_nettype none

interface lrn_in_if;
  import lrn_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [VAL_W-1:0]  value;
  logic [N_W-1:0]    term_index;
  modport source (output valid, command, slot, value, term_index, input ready);
  modport sink (input valid, command, slot, value, term_index, output ready);
endinterface

interface lrn_out_if;
  import lrn_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] term_value;
  modport source (output valid, term_value, input ready);
  modport sink (input valid, term_value, output ready);
endinterface

`default_nettype wire

[rtl/core/linear_recurrence_nth_term_mod_top.sv]
// n-th term of a linear recurrence of order k (the order register, 0..31, saturated at 16)
// modulo 1000000007. Load items (command 0 coefficient, 1 initial term) give no result;
// command 3 is dropped. A query (command 2) gives one item on out_ch. A query with n
// below k reads the initial term directly; at order 0 a query gives zero. Otherwise
// the block squares and multiplies polynomial vectors over the bits of n, each step one
// multiply-accumulate on a single pipelined modular multiplier fed from one table memory
// with one read and one write port. A step does two table reads, passes the four
// multiplier stages and writes back to the table or, in the dot product, to acc. One vector
// composition does two steps per pair of entries, plus vector copies and row set-up; a
// query does one composition per bit of n and one more per set bit after set-up, then a
// dot product with the initial terms. in_ch is ready only while no query is in progress;
// a finished result waits in the output register while further loads are taken. The order
// register sits at byte addresses 0 to 3 of the APB port and reads back.
`default_nettype none
`include "linear_recurrence_nth_term_mod_top_assert.svh"

module linear_recurrence_nth_term_mod_top (
  input  logic                clk,
  input  logic                rst,
  lrn_in_if.sink              in_ch,
  lrn_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lrn_pkg::*;

  // Sequencer states
  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_SMALL_RD = 5'd1;
  localparam logic [4:0] ST_SMALL_WT = 5'd2;
  localparam logic [4:0] ST_INIT_RES = 5'd3;
  localparam logic [4:0] ST_INIT_POW = 5'd4;
  localparam logic [4:0] ST_BIT      = 5'd5;
  localparam logic [4:0] ST_CP_RD    = 5'd6;
  localparam logic [4:0] ST_CP_WR    = 5'd7;
  localparam logic [4:0] ST_LDA_RD   = 5'd8;
  localparam logic [4:0] ST_LDA_WT   = 5'd9;
  localparam logic [4:0] ST_PROD_GO  = 5'd10;
  localparam logic [4:0] ST_PROD_NXT = 5'd11;
  localparam logic [4:0] ST_TOP_RD   = 5'd12;
  localparam logic [4:0] ST_TOP_WT   = 5'd13;
  localparam logic [4:0] ST_SHF_GO   = 5'd14;
  localparam logic [4:0] ST_SHF_NXT  = 5'd15;
  localparam logic [4:0] ST_ROW_END  = 5'd16;
  localparam logic [4:0] ST_PASS_END = 5'd17;
  localparam logic [4:0] ST_DOT_GO   = 5'd18;
  localparam logic [4:0] ST_DOT_NXT  = 5'd19;
  localparam logic [4:0] ST_DONE     = 5'd20;
  localparam logic [4:0] ST_OP_RD1   = 5'd21;
  localparam logic [4:0] ST_OP_RD2   = 5'd22;
  localparam logic [4:0] ST_OP_ISSUE = 5'd23;
  localparam logic [4:0] ST_OP_WAIT  = 5'd24;

  // Multiply-accumulate step kinds
  localparam logic [1:0] OP_MUL = 2'd0;  // x*y
  localparam logic [1:0] OP_MAC = 2'd1;  // mem + x*y
  localparam logic [1:0] OP_DOT = 2'd2;  // acc + mem*mem

  // Table regions, each MAX_ORDER entries
  localparam logic [2:0] RG_COEF  = 3'd0;
  localparam logic [2:0] RG_INIT  = 3'd1;
  localparam logic [2:0] RG_POW   = 3'd2;
  localparam logic [2:0] RG_RES   = 3'd3;
  localparam logic [2:0] RG_SHIFT = 3'd4;
  localparam logic [2:0] RG_PROD  = 3'd5;

  localparam int ADDR_W = 3 + SLOT_W;

  logic [VAL_W-1:0] mem [2**ADDR_W];
  logic [VAL_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;
  logic [VAL_W-1:0]  wr_data;

  logic [4:0]        state;
  logic [ORDER_W-1:0] order;
  logic [N_W-1:0]    n;
  logic [SLOT_W-1:0] i, j;
  logic              pass;      // low: result vector update, high: squaring
  logic              cp_final;  // low: operand into shift, high: product out
  logic [VAL_W-1:0]  xreg, d1, acc;
  logic [1:0]        op_mode;
  logic [ADDR_W-1:0] op_a1, op_a2, op_dst;
  logic [4:0]        op_after;
  logic              out_valid;
  logic [VAL_W-1:0]  out_data;

  logic [ORDER_W-1:0] k_eff;
  logic [SLOT_W-1:0]  km1;
  logic               in_fire, cfg_wr;
  logic [VAL_W-1:0]   load_val;
  logic [2:0]         pass_rg, cp_src, cp_dst;
  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;

  lrn_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // Saturate the order at the table depth
  assign k_eff    = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;
  assign km1      = SLOT_W'(k_eff - ORDER_W'(1));
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign load_val = (in_ch.value >= PRIME) ? in_ch.value - PRIME : in_ch.value;
  assign pass_rg  = pass ? RG_POW : RG_RES;
  assign cp_src   = cp_final ? RG_PROD : pass_rg;
  assign cp_dst   = cp_final ? pass_rg : RG_SHIFT;

  assign in_ch.ready       = (state == ST_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.term_value = out_data;

  // APB: addresses 0 to 3 hold the order, addresses 4 to 7 read zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? {27'b0, order} : 32'b0;

  // Multiplier operands: x from xreg except in the final dot product, where it is the first table operand
  always_comb begin
    mul_req.start  = (state == ST_OP_ISSUE);
    mul_req.x      = (op_mode == OP_DOT) ? d1 : xreg;
    mul_req.y      = rdata;
    mul_req.addend = (op_mode == OP_MAC) ? d1 : ((op_mode == OP_DOT) ? acc : '0);
  end

  // Table read address
  always_comb begin
    case (state)
      ST_SMALL_RD: rd_addr = {RG_INIT, n[SLOT_W-1:0]};
      ST_CP_RD:    rd_addr = {cp_src, j};
      ST_LDA_RD:   rd_addr = {RG_POW, i};
      ST_TOP_RD:   rd_addr = {RG_SHIFT, km1};
      ST_OP_RD1:   rd_addr = op_a1;
      ST_OP_RD2:   rd_addr = op_a2;
      default:     rd_addr = op_a2;
    endcase
  end

  // Table write port: loads, vector set-up, copies and step write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = op_dst;
    wr_data = mul_rsp.value;
    case (state)
      ST_IDLE: begin
        wr_en   = in_fire && (in_ch.command == CMD_LOAD_COEF ||
                              in_ch.command == CMD_LOAD_INIT);
        wr_addr = {(in_ch.command == CMD_LOAD_COEF) ? RG_COEF : RG_INIT, in_ch.slot};
        wr_data = load_val;
      end
      ST_INIT_RES: begin
        wr_en   = 1'b1;
        wr_addr = {RG_RES, j};
        wr_data = (j == '0) ? VAL_W'(1) : '0;
      end
      ST_INIT_POW: begin
        wr_en   = (km1 != '0);
        wr_addr = {RG_POW, j};
        wr_data = (j == SLOT_W'(1)) ? VAL_W'(1) : '0;
      end
      ST_CP_WR: begin
        wr_en   = 1'b1;
        wr_addr = {cp_dst, j};
        wr_data = rdata;
      end
      ST_OP_WAIT: begin
        wr_en   = mul_rsp.valid && (op_mode != OP_DOT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      order     <= ORDER_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == 1'b0) begin
        order <= pwdata[ORDER_W-1:0];
      end
      // Drop the result once taken, unless a new one replaces it
      if (out_valid && out_ch.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && in_ch.command == CMD_QUERY) begin
            n <= in_ch.term_index;
            i <= '0;
            j <= '0;
            if (in_ch.term_index < N_W'(k_eff)) begin
              state <= ST_SMALL_RD;
            end else if (k_eff == '0) begin
              acc   <= '0;
              state <= ST_DONE;
            end else begin
              state <= ST_INIT_RES;
            end
          end
        end
        ST_SMALL_RD: state <= ST_SMALL_WT;
        ST_SMALL_WT: begin
          acc   <= rdata;
          state <= ST_DONE;
        end
        ST_INIT_RES: begin
          if (j == km1) begin
            j     <= '0;
            state <= ST_INIT_POW;
          end else begin
            j <= j + SLOT_W'(1);
          end
        end
        ST_INIT_POW: begin
          if (km1 == '0) begin
            // Order one: x reduces to the single coefficient
            xreg     <= VAL_W'(1);
            op_mode  <= OP_MUL;
            op_a1    <= {RG_COEF, SLOT_W'(0)};
            op_a2    <= {RG_COEF, SLOT_W'(0)};
            op_dst   <= {RG_POW, SLOT_W'(0)};
            op_after <= ST_BIT;
            state    <= ST_OP_RD1;
          end else if (j == km1) begin
            state <= ST_BIT;
          end else begin
            j <= j + SLOT_W'(1);
          end
        end
        ST_BIT: begin
          if (n == '0) begin
            acc   <= '0;
            i     <= '0;
            state <= ST_DOT_GO;
          end else begin
            pass     <= ~n[0];
            cp_final <= 1'b0;
            j        <= '0;
            state    <= ST_CP_RD;
          end
        end
        ST_CP_RD: state <= ST_CP_WR;
        ST_CP_WR: begin
          if (j == km1) begin
            j <= '0;
            i <= '0;
            state <= cp_final ? ST_PASS_END : ST_LDA_RD;
          end else begin
            j     <= j + SLOT_W'(1);
            state <= ST_CP_RD;
          end
        end
        ST_LDA_RD: state <= ST_LDA_WT;
        ST_LDA_WT: begin
          xreg  <= rdata;
          j     <= '0;
          state <= ST_PROD_GO;
        end
        ST_PROD_GO: begin
          // First row starts the product from zero
          op_mode  <= (i == '0) ? OP_MUL : OP_MAC;
          op_a1    <= {RG_PROD, j};
          op_a2    <= {RG_SHIFT, j};
          op_dst   <= {RG_PROD, j};
          op_after <= ST_PROD_NXT;
          state    <= ST_OP_RD1;
        end
        ST_PROD_NXT: begin
          if (j == km1) begin
            state <= ST_TOP_RD;
          end else begin
            j     <= j + SLOT_W'(1);
            state <= ST_PROD_GO;
          end
        end
        ST_TOP_RD: state <= ST_TOP_WT;
        ST_TOP_WT: begin
          xreg  <= rdata;
          j     <= km1;
          state <= ST_SHF_GO;
        end
        ST_SHF_GO: begin
          // Multiply the shift vector by x, reduce the overflow by the coefficients
          op_mode  <= (j == '0) ? OP_MUL : OP_MAC;
          op_a1    <= {RG_SHIFT, SLOT_W'(j - SLOT_W'(1))};
          op_a2    <= {RG_COEF, j};
          op_dst   <= {RG_SHIFT, j};
          op_after <= ST_SHF_NXT;
          state    <= ST_OP_RD1;
        end
        ST_SHF_NXT: begin
          if (j == '0) begin
            state <= ST_ROW_END;
          end else begin
            j     <= j - SLOT_W'(1);
            state <= ST_SHF_GO;
          end
        end
        ST_ROW_END: begin
          if (i == km1) begin
            cp_final <= 1'b1;
            j        <= '0;
            state    <= ST_CP_RD;
          end else begin
            i     <= i + SLOT_W'(1);
            state <= ST_LDA_RD;
          end
        end
        ST_PASS_END: begin
          if (!pass) begin
            pass     <= 1'b1;
            cp_final <= 1'b0;
            j        <= '0;
            state    <= ST_CP_RD;
          end else begin
            n     <= n >> 1;
            state <= ST_BIT;
          end
        end
        ST_DOT_GO: begin
          op_mode  <= OP_DOT;
          op_a1    <= {RG_RES, i};
          op_a2    <= {RG_INIT, i};
          op_dst   <= {RG_RES, i};
          op_after <= ST_DOT_NXT;
          state    <= ST_OP_RD1;
        end
        ST_DOT_NXT: begin
          if (i == km1) begin
            state <= ST_DONE;
          end else begin
            i     <= i + SLOT_W'(1);
            state <= ST_DOT_GO;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_data  <= acc;
            state     <= ST_IDLE;
          end
        end
        ST_OP_RD1: state <= ST_OP_RD2;
        ST_OP_RD2: begin
          d1    <= rdata;
          state <= ST_OP_ISSUE;
        end
        ST_OP_ISSUE: state <= ST_OP_WAIT;
        ST_OP_WAIT: begin
          if (mul_rsp.valid) begin
            if (op_mode == OP_DOT) begin
              acc <= mul_rsp.value;
            end
            state <= op_after;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LRN_ASSERT_HOLD(a_out_reduced, out_valid, out_data < PRIME, "result not reduced")
  `LRN_ASSERT_HOLD(a_wr_reduced, wr_en, wr_data < PRIME, "table write not reduced")
  `LRN_ASSERT_HOLD(a_rsp_in_wait, mul_rsp.valid, state == ST_OP_WAIT, "stray product")

endmodule

`default_nettype wire

[rtl/core/lrn_mulmod.sv]
`default_nettype none

// x*y + addend mod PRIME, four-stage Barrett pipeline.
module lrn_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  lrn_pkg::mul_req_t req,
  output lrn_pkg::mul_rsp_t rsp
);
  import lrn_pkg::*;

  logic        v1, v2, v3;
  logic [59:0] prod1, prod2, prod3;
  logic [61:0] t2;
  logic [60:0] qp3;
  logic [32:0] r0, r1, r2, r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      v1        <= req.start;
      v2        <= v1;
      v3        <= v2;
      rsp.valid <= v3;
    end
    prod1     <= ({30'b0, req.x} * {30'b0, req.y}) + {30'b0, req.addend};
    t2        <= {31'b0, prod1[59:29]} * {31'b0, MU};
    prod2     <= prod1;
    qp3       <= {30'b0, t2[61:31]} * {31'b0, PRIME};
    prod3     <= prod2;
    rsp.value <= r3[VAL_W-1:0];
  end

  // Estimate is at most three short of the true quotient.
  always_comb begin
    r0 = prod3[32:0] - qp3[32:0];
    r1 = (r0 >= {3'b0, PRIME}) ? r0 - {3'b0, PRIME} : r0;
    r2 = (r1 >= {3'b0, PRIME}) ? r1 - {3'b0, PRIME} : r1;
    r3 = (r2 >= {3'b0, PRIME}) ? r2 - {3'b0, PRIME} : r2;
  end

endmodule

`default_nettype wire

[tb/lrn_if.sv]
// The channel interfaces lrn_in_if and lrn_out_if are compiled from the RTL folder.

[tb/tb_linear_recurrence_nth_term_mod_top.sv]
`default_nettype none

module tb_linear_recurrence_nth_term_mod_top;
  import lrn_pkg::*;

  localparam logic [2:0] ADDR_ORDER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam longint unsigned MODULUS = 64'd1000000007;

  typedef logic [VAL_W-1:0] term_vec_t [MAX_ORDER];

  // Recurrence predictor and store of expected term values.
  class term_scoreboard;
    logic [VAL_W-1:0]   coef_tab [MAX_ORDER];
    logic [VAL_W-1:0]   init_tab [MAX_ORDER];
    logic [ORDER_W-1:0] order_reg = 5'd1;
    logic [VAL_W-1:0]   expected_terms [$];
    int                 errors = 0;

    function logic [VAL_W-1:0] mul_mod(longint unsigned a, longint unsigned b);
      return VAL_W'((a * b) % MODULUS);
    endfunction

    // Product of two polynomials in x, reduced by the characteristic polynomial.
    function term_vec_t compose(term_vec_t a, term_vec_t b, int k);
      term_vec_t sh;
      term_vec_t prod;
      logic [VAL_W-1:0] top;
      sh = b;
      foreach (prod[j]) prod[j] = '0;
      for (int i = 0; i < k; i++) begin
        for (int j = 0; j < k; j++)
          prod[j] = VAL_W'((64'(prod[j]) + 64'(a[i]) * 64'(sh[j])) % MODULUS);
        top = sh[k-1];
        for (int j = k - 1; j > 0; j--)
          sh[j] = VAL_W'((64'(sh[j-1]) + 64'(top) * 64'(coef_tab[j])) % MODULUS);
        sh[0] = mul_mod(top, coef_tab[0]);
      end
      return prod;
    endfunction

    function logic [VAL_W-1:0] nth_term(logic [N_W-1:0] n_in);
      int k;
      logic [N_W-1:0] n;
      logic [VAL_W-1:0] acc_pow;
      logic [VAL_W-1:0] base;
      term_vec_t res;
      term_vec_t pw;
      longint unsigned dot;
      n = n_in;
      k = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
      if (n < k) return init_tab[n];
      if (k == 0) return '0;
      if (k == 1) begin
        acc_pow = 1;
        base = coef_tab[0];
        while (n != 0) begin
          if (n[0]) acc_pow = mul_mod(acc_pow, base);
          base = mul_mod(base, base);
          n = n >> 1;
        end
        return mul_mod(init_tab[0], acc_pow);
      end
      foreach (res[i]) begin
        res[i] = '0;
        pw[i] = '0;
      end
      res[0] = 1;
      pw[1] = 1;
      while (n != 0) begin
        if (n[0]) res = compose(pw, res, k);
        pw = compose(pw, pw, k);
        n = n >> 1;
      end
      dot = 0;
      for (int i = 0; i < k; i++)
        dot = (dot + 64'(res[i]) * 64'(init_tab[i])) % MODULUS;
      return VAL_W'(dot);
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [VAL_W-1:0] value, logic [N_W-1:0] n);
      logic [VAL_W-1:0] reduced;
      reduced = VAL_W'(64'(value) % MODULUS);
      case (cmd)
        CMD_LOAD_COEF: coef_tab[slot] = reduced;
        CMD_LOAD_INIT: init_tab[slot] = reduced;
        CMD_QUERY:     expected_terms.push_back(nth_term(n));
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_term(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (expected_terms.size() == 0) begin
        report($sformatf("term_value %0d with no query pending", got));
        return;
      end
      want = expected_terms.pop_front();
      if (got !== want)
        report($sformatf("term_value got %0d want %0d", got, want));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lrn_in_if  in_ch ();
  lrn_out_if out_ch ();

  term_scoreboard sb = new();

  // Idling control; no_gaps gives both sides stretches at full rate.
  bit no_gaps = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  linear_recurrence_nth_term_mod_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Mostly no gap, sometimes a short one, now and then a long one.
  function int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD_COEF;
    in_ch.slot = '0;
    in_ch.value = '0;
    in_ch.term_index = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: check each accepted item, then decide ready for the next cycle.
  // A requested long hold is counted here, cycle by cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_term(out_ch.term_value);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_served < hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left <= 400;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (pick_gap() == 0);
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one item after a random gap; hold valid high when no gap follows.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                           logic [VAL_W-1:0] value, logic [N_W-1:0] n);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.slot <= slot;
    in_ch.value <= value;
    in_ch.term_index <= n;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(cmd, slot, value, n);
  endtask

  // Drop valid, drain every expected term, let any trailing load settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_terms.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function logic [VAL_W-1:0] rand_value();
    if ($urandom_range(0, 9) == 0)
      return VAL_W'($urandom_range(32'h3FFF_FFFF, 32'd1000000007));
    return VAL_W'($urandom % 32'd1000000007);
  endfunction

  // Random phase at one order; n width is capped for high orders to bound run time.
  task automatic run_phase(logic [4:0] ord, int count);
    int k;
    int r;
    int nbits;
    logic [63:0] wide;
    logic [N_W-1:0] n;
    drain();
    apb_write(ADDR_ORDER, 32'(ord));
    sb.order_reg = ord;
    k = (ord > MAX_ORDER) ? MAX_ORDER : int'(ord);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22) send_item(CMD_LOAD_COEF, SLOT_W'($urandom), rand_value(), N_W'($urandom));
      else if (r < 44) send_item(CMD_LOAD_INIT, SLOT_W'($urandom), rand_value(), '0);
      else if (r < 48) send_item(CMD_UNUSED, SLOT_W'($urandom), rand_value(), N_W'($urandom));
      else begin
        nbits = (k >= 8) ? $urandom_range(1, 8) : (k >= 4) ? $urandom_range(1, 24)
                                                         : $urandom_range(1, 63);
        wide = {$urandom, $urandom};
        n = N_W'(wide & ((64'd1 << nbits) - 1));
        if ($urandom_range(0, 4) == 0 && k > 0) n = N_W'($urandom_range(0, k - 1));
        send_item(CMD_QUERY, SLOT_W'($urandom), VAL_W'($urandom), n);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Order one after reset: extremes, unreduced value, unused command.
    send_item(CMD_LOAD_COEF, 4'd0, 30'd1000000006, '0);
    send_item(CMD_LOAD_INIT, 4'd0, 30'h3FFF_FFFF, '1);
    send_item(CMD_UNUSED, 4'hF, 30'h3FFF_FFFF, '1);
    send_item(CMD_QUERY, 4'd0, '0, '0);
    send_item(CMD_QUERY, 4'hF, '1, 63'd1);
    send_item(CMD_QUERY, 4'd0, '0, '1);
    send_item(CMD_LOAD_COEF, 4'd0, 30'd0, '0);
    send_item(CMD_QUERY, 4'd0, '0, 63'd7);

    // Fill both tables so every later query reads written entries only.
    for (int s = 0; s < MAX_ORDER; s++) begin
      send_item(CMD_LOAD_COEF, SLOT_W'(s), rand_value(), '0);
      send_item(CMD_LOAD_INIT, SLOT_W'(s), rand_value(), '0);
    end

    run_phase(5'd2, 14);
    send_item(CMD_QUERY, 4'd0, '0, '1);
    run_phase(5'd0, 8);
    no_gaps = 1'b1;
    run_phase(5'd3, 12);
    no_gaps = 1'b0;
    run_phase(5'd16, 6);
    send_item(CMD_QUERY, 4'd0, '0, 63'd15);
    run_phase(5'd31, 5);
    run_phase(5'd5, 10);
    run_phase(5'd1, 10);

    // Hold off the result side for a long stretch while queries keep coming;
    // short queries fill the output register and stall the input.
    drain();
    hold_requests = hold_requests + 1;
    send_item(CMD_QUERY, 4'd0, '0, '0);
    send_item(CMD_QUERY, 4'd1, '0, '0);
    send_item(CMD_QUERY, 4'd2, '0, '0);
    run_phase(5'd2, 14);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/lrn_pkg.sv
rtl/core/lrn_if.sv
rtl/core/lrn_mulmod.sv
rtl/core/linear_recurrence_nth_term_mod_top.sv
tb/lrn_if.sv
tb/tb_linear_recurrence_nth_term_mod_top.sv
